// ===== rtl/pst_pkg.sv =====
// Shared types and constants for the process slot table.
// Used by every module of the block but pst_ram; depends on nothing else.
`timescale 1ns / 1ps

package pst_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam logic [31:0] FIRST_ID_RESET = 32'd5000;

    localparam int ID_W    = 32;
    localparam int SLOT_W  = 5;
    localparam int WORD_W  = 64;
    localparam int VEC_W   = 8;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_EXIT  = 2'd1,
        OP_FAULT = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_UNUSED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RUN_EMPTY   = 2'd0,
        RUN_RUNNING = 2'd1,
        RUN_EXITED  = 2'd2,
        RUN_FAULTED = 2'd3
    } t_run;

    // Identity part of a slot, read on every step of the allocation scan.
    typedef struct packed {
        logic [ID_W-1:0] id;
        t_run            run;
    } t_rec_a;

    // Bulk part of a slot record.
    typedef struct packed {
        logic [WORD_W-1:0] ret_code;
        logic [WORD_W-1:0] entry;
        logic [WORD_W-1:0] root;
        logic [WORD_W-1:0] tick_start;
        logic [WORD_W-1:0] tick_end;
        logic [VEC_W-1:0]  vector;
        logic [WORD_W-1:0] fault_addr;
    } t_rec_b;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_run;
        logic alloc_commit;
        logic set_full;
        logic rd_issue;
        logic rmw;
        logic set_unused;
        logic out_load;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;
        logic pick_found;
        logic slot_ok;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/pst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pst_ctrl.sv =====
// Sequencing state machine for the process slot table.
// Uses pst_pkg for the command and status structs and the op codes.
`timescale 1ns / 1ps

module pst_ctrl
    import pst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_MODIFY,
        S_REPORT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (t_op'(i_op) == OP_ALLOC) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    if (i_stat.pick_found) begin
                        o_cmd.alloc_commit = 1'b1;
                    end else begin
                        o_cmd.set_full = 1'b1;
                    end
                    n_state = S_REPORT;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_MODIFY;
            end
            S_MODIFY: begin
                if (i_stat.slot_ok) begin
                    o_cmd.rmw = 1'b1;
                end else begin
                    o_cmd.set_unused = 1'b1;
                end
                n_state = S_REPORT;
            end
            S_REPORT: begin
                // hold the result until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/pst_datapath.sv =====
// Slot storage, allocation scan, record update and output register.
// Uses pst_pkg and two pst_ram instances for the slot records.
`timescale 1ns / 1ps

module pst_datapath
    import pst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_cfg_we,
    input  logic [ID_W-1:0]          i_cfg_wdata,
    input  logic [1:0]               i_op,
    input  logic [SLOT_W-1:0]        i_slot,
    input  logic [WORD_W-1:0]        i_entry_address,
    input  logic [WORD_W-1:0]        i_table_root,
    input  logic [WORD_W-1:0]        i_now_tick,
    input  logic signed [WORD_W-1:0] i_exit_value,
    input  logic [VEC_W-1:0]         i_fault_number,
    input  logic [WORD_W-1:0]        i_fault_address,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic [SLOT_W-1:0]        o_slot_out,
    output logic [ID_W-1:0]          o_process_id,
    output logic [1:0]               o_run_state,
    output logic signed [WORD_W-1:0] o_exit_out,
    output logic [WORD_W-1:0]        o_elapsed,
    output logic [VEC_W-1:0]         o_vector_out,
    output logic [WORD_W-1:0]        o_address_out,
    output logic [WORD_W-1:0]        o_entry_out,
    output logic [WORD_W-1:0]        o_root_out
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = SW + 1;
    localparam int XW = SW + SLOT_W;
    localparam int AW_BITS = $bits(t_rec_a);
    localparam int BW_BITS = $bits(t_rec_b);

    // captured request
    t_op                r_in_op;
    logic [SLOT_W-1:0]  r_in_slot;
    logic [WORD_W-1:0]  r_in_entry;
    logic [WORD_W-1:0]  r_in_root;
    logic [WORD_W-1:0]  r_in_now;
    logic [WORD_W-1:0]  r_in_exit;
    logic [VEC_W-1:0]   r_in_vec;
    logic [WORD_W-1:0]  r_in_faddr;

    // control state
    logic [SLOTS-1:0]   r_valid;
    logic [ID_W-1:0]    r_id_ctr;
    logic [CW-1:0]      r_scan_addr;
    logic               r_cmp_vld;
    logic               r_free_found;
    logic               r_best_found;
    logic               r_out_valid;

    // scan payload
    logic [SW-1:0]      r_cmp_idx;
    logic [SW-1:0]      r_free_idx;
    logic [SW-1:0]      r_best_idx;
    logic [ID_W-1:0]    r_best_id;
    logic               r_rd_valid;

    // record being reported
    t_status            r_status;
    logic [SLOT_W-1:0]  r_rec_slot;
    t_rec_a             r_rec_a;
    t_rec_b             r_rec_b;

    // output register
    t_status            r_out_status;
    logic [SLOT_W-1:0]  r_out_slot;
    t_rec_a             r_out_a;
    t_rec_b             r_out_b;
    logic [WORD_W-1:0]  r_out_elapsed;

    logic               scan_issue;
    logic               rd_en;
    logic [SW-1:0]      rd_addr;
    logic [XW-1:0]      slot_ext;
    logic [SW-1:0]      slot_idx;
    logic               slot_in_range;
    logic [SW-1:0]      pick;
    logic [XW-1:0]      pick_ext;
    logic               we;
    logic [SW-1:0]      waddr;
    logic [AW_BITS-1:0] a_rdata;
    logic [BW_BITS-1:0] b_rdata;
    t_rec_a             rd_a;
    t_rec_b             rd_b;
    t_rec_a             n_alloc_a;
    t_rec_b             n_alloc_b;
    t_rec_a             n_mod_a;
    t_rec_b             n_mod_b;
    t_rec_a             n_wr_a;
    t_rec_b             n_wr_b;
    logic               rec_ok;
    logic               end_later;
    logic [WORD_W-1:0]  d_end;
    logic [WORD_W-1:0]  d_now;

    assign slot_ext      = XW'(r_in_slot);
    assign slot_idx      = slot_ext[SW-1:0];
    assign slot_in_range = (slot_ext < XW'(SLOTS));

    assign scan_issue = (r_scan_addr < CW'(SLOTS));
    assign rd_en      = (i_cmd.scan_run && scan_issue) || i_cmd.rd_issue;
    assign rd_addr    = i_cmd.rd_issue ? slot_idx : r_scan_addr[SW-1:0];

    assign pick     = r_free_found ? r_free_idx : r_best_idx;
    assign pick_ext = XW'(pick);

    assign rd_a = t_rec_a'(a_rdata);
    assign rd_b = t_rec_b'(b_rdata);

    // fresh record for a newly allocated slot
    always_comb begin
        n_alloc_a.id          = r_id_ctr;
        n_alloc_a.run         = RUN_RUNNING;
        n_alloc_b.ret_code    = '1;
        n_alloc_b.entry       = r_in_entry;
        n_alloc_b.root        = r_in_root;
        n_alloc_b.tick_start  = r_in_now;
        n_alloc_b.tick_end    = '0;
        n_alloc_b.vector      = '0;
        n_alloc_b.fault_addr  = '0;
    end

    // exit and fault update of a record read back from the RAMs
    always_comb begin
        n_mod_a = rd_a;
        n_mod_b = rd_b;
        case (r_in_op)
            OP_EXIT: begin
                n_mod_a.run        = RUN_EXITED;
                n_mod_b.ret_code   = r_in_exit;
                n_mod_b.tick_end   = r_in_now;
            end
            OP_FAULT: begin
                n_mod_a.run        = RUN_FAULTED;
                n_mod_b.ret_code   = '1;
                n_mod_b.tick_end   = r_in_now;
                n_mod_b.vector     = r_in_vec;
                n_mod_b.fault_addr = r_in_faddr;
            end
            default: begin
            end
        endcase
    end

    assign we     = i_cmd.alloc_commit || (i_cmd.rmw && (r_in_op != OP_QUERY));
    assign waddr  = i_cmd.alloc_commit ? pick : slot_idx;
    assign n_wr_a = i_cmd.alloc_commit ? n_alloc_a : n_mod_a;
    assign n_wr_b = i_cmd.alloc_commit ? n_alloc_b : n_mod_b;

    pst_ram #(
        .WIDTH (AW_BITS),
        .DEPTH (SLOTS)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (n_wr_a),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (a_rdata)
    );

    pst_ram #(
        .WIDTH (BW_BITS),
        .DEPTH (SLOTS)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (n_wr_b),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (b_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_id_ctr     <= FIRST_ID_RESET;
            r_scan_addr  <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_id_ctr <= i_cfg_wdata;
            end else if (i_cmd.alloc_commit) begin
                r_id_ctr <= r_id_ctr + 1'b1;
            end

            if (i_cmd.alloc_commit) begin
                r_valid[pick] <= 1'b1;
            end

            if (i_cmd.scan_init) begin
                r_scan_addr  <= '0;
                r_cmp_vld    <= 1'b0;
                r_free_found <= 1'b0;
                r_best_found <= 1'b0;
            end else if (i_cmd.scan_run) begin
                if (scan_issue) begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                end
                r_cmp_vld <= scan_issue;
                if (r_cmp_vld) begin
                    if (!r_rd_valid) begin
                        r_free_found <= 1'b1;
                    end else if (rd_a.run != RUN_RUNNING) begin
                        r_best_found <= 1'b1;
                    end
                end
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_op    <= t_op'(i_op);
            r_in_slot  <= i_slot;
            r_in_entry <= i_entry_address;
            r_in_root  <= i_table_root;
            r_in_now   <= i_now_tick;
            r_in_exit  <= i_exit_value;
            r_in_vec   <= i_fault_number;
            r_in_faddr <= i_fault_address;
        end

        if (rd_en) begin
            // a slot past the table end reads as unused
            r_rd_valid <= i_cmd.rd_issue ? (slot_in_range && r_valid[slot_idx])
                                         : r_valid[rd_addr];
        end

        if (i_cmd.scan_run && scan_issue) begin
            r_cmp_idx <= r_scan_addr[SW-1:0];
        end

        // first free slot wins; otherwise the finished slot with the lowest id
        if (i_cmd.scan_run && r_cmp_vld) begin
            if (!r_rd_valid) begin
                if (!r_free_found) begin
                    r_free_idx <= r_cmp_idx;
                end
            end else if (rd_a.run != RUN_RUNNING &&
                         (!r_best_found || rd_a.id < r_best_id)) begin
                r_best_idx <= r_cmp_idx;
                r_best_id  <= rd_a.id;
            end
        end

        if (i_cmd.alloc_commit) begin
            r_status   <= ST_OK;
            r_rec_slot <= pick_ext[SLOT_W-1:0];
            r_rec_a    <= n_alloc_a;
            r_rec_b    <= n_alloc_b;
        end else if (i_cmd.set_full) begin
            r_status   <= ST_FULL;
            r_rec_slot <= '0;
        end else if (i_cmd.rmw) begin
            r_status   <= ST_OK;
            r_rec_slot <= r_in_slot;
            r_rec_a    <= n_mod_a;
            r_rec_b    <= n_mod_b;
        end else if (i_cmd.set_unused) begin
            r_status   <= ST_UNUSED;
            r_rec_slot <= r_in_slot;
        end

        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_slot   <= r_rec_slot;
            r_out_a      <= rec_ok ? r_rec_a : '0;
            r_out_b      <= rec_ok ? r_rec_b : '0;
            r_out_elapsed <= rec_ok ? (end_later ? d_end : d_now) : '0;
        end
    end

    assign rec_ok    = (r_status == ST_OK);
    assign end_later = (r_rec_b.tick_end > r_rec_b.tick_start);
    assign d_end     = r_rec_b.tick_end - r_rec_b.tick_start;
    assign d_now     = r_in_now - r_rec_b.tick_start;

    assign o_stat.scan_done  = !scan_issue && !r_cmp_vld;
    assign o_stat.pick_found = r_free_found || r_best_found;
    assign o_stat.slot_ok    = slot_in_range && r_rd_valid;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_out    = r_out_slot;
    assign o_process_id  = r_out_a.id;
    assign o_run_state   = r_out_a.run;
    assign o_exit_out    = r_out_b.ret_code;
    assign o_elapsed     = r_out_elapsed;
    assign o_vector_out  = r_out_b.vector;
    assign o_address_out = r_out_b.fault_addr;
    assign o_entry_out   = r_out_b.entry;
    assign o_root_out    = r_out_b.root;

endmodule

// ===== rtl/process_slot_table_top.sv =====
// Process slot table: one request in, one result out per request.
//
// Requests enter on i_in_valid / o_in_stall with op, slot and the operand
// fields; results leave on o_out_valid / i_out_stall. A channel transfers at
// a clock edge where valid is high and stall is low. i_cfg_we with
// i_cfg_wdata loads the id handed to the next allocation; write it only
// while the block is idle.
//
// Allocate scans every slot through the identity RAM, one slot per cycle.
// Exit and fault do one read-modify-write of the slot record; query only
// reads it. The next request is taken only once the result of the last
// one has been loaded into the output register.
//
// Reset (synchronous, active low) marks every slot empty and reloads the id
// counter with 5000; there is no clearing pass. A finished result sits in the
// output register while the receiver stalls; one more request may be taken
// meanwhile, and its result waits until the register is free.
// Depends on pst_pkg, pst_ctrl, pst_datapath and pst_ram.
`timescale 1ns / 1ps

module process_slot_table_top
    import pst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [ID_W-1:0]          i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic [SLOT_W-1:0]        i_slot,
    input  logic [WORD_W-1:0]        i_entry_address,
    input  logic [WORD_W-1:0]        i_table_root,
    input  logic [WORD_W-1:0]        i_now_tick,
    input  logic signed [WORD_W-1:0] i_exit_value,
    input  logic [VEC_W-1:0]         i_fault_number,
    input  logic [WORD_W-1:0]        i_fault_address,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic [SLOT_W-1:0]        o_slot_out,
    output logic [ID_W-1:0]          o_process_id,
    output logic [1:0]               o_run_state,
    output logic signed [WORD_W-1:0] o_exit_out,
    output logic [WORD_W-1:0]        o_elapsed,
    output logic [VEC_W-1:0]         o_vector_out,
    output logic [WORD_W-1:0]        o_address_out,
    output logic [WORD_W-1:0]        o_entry_out,
    output logic [WORD_W-1:0]        o_root_out
);

    t_cmd  cmd;
    t_stat stat;

    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pst_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op            (i_op),
        .i_slot          (i_slot),
        .i_entry_address (i_entry_address),
        .i_table_root    (i_table_root),
        .i_now_tick      (i_now_tick),
        .i_exit_value    (i_exit_value),
        .i_fault_number  (i_fault_number),
        .i_fault_address (i_fault_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot_out      (o_slot_out),
        .o_process_id    (o_process_id),
        .o_run_state     (o_run_state),
        .o_exit_out      (o_exit_out),
        .o_elapsed       (o_elapsed),
        .o_vector_out    (o_vector_out),
        .o_address_out   (o_address_out),
        .o_entry_out     (o_entry_out),
        .o_root_out      (o_root_out)
    );

endmodule

// ===== rtl/pst_checker.sv =====
// Port-level checks for the process slot table, bound to the top level.
// Depends on pst_pkg for the status and run state codes.
`timescale 1ns / 1ps

module pst_checker
    import pst_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic [1:0]               o_status,
    input logic [SLOT_W-1:0]        o_slot_out,
    input logic [ID_W-1:0]          o_process_id,
    input logic [1:0]               o_run_state,
    input logic [WORD_W-1:0]        o_elapsed
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a taken request keeps the input side busy in the cycle after it
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while previous one still in flight");

    // a successful result always describes a live slot
    a_ok_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |-> (o_run_state != RUN_EMPTY))
        else $error("ok result reports an empty slot");

    // failed requests carry no record
    a_fail_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL || o_status == ST_UNUSED))
        |-> (o_process_id == '0 && o_run_state == RUN_EMPTY && o_elapsed == '0
             && (o_status == ST_UNUSED || o_slot_out == '0)))
        else $error("failed request returned record data");

endmodule

bind process_slot_table_top pst_checker u_pst_checker (.*);

// ===== tb/process_slot_table_top_tb.sv =====
// Self-checking testbench for process_slot_table_top: directed and random
// requests, with a predictor of the slot table compared against every result.
// Depends on pst_pkg and the process_slot_table_top RTL.
`timescale 1ns / 1ps

module process_slot_table_top_tb;
    import pst_pkg::*;

    localparam int NUM_SLOTS = SLOTS_DEFAULT;

    typedef struct {
        t_op                op;
        logic [SLOT_W-1:0]  slot;
        logic [WORD_W-1:0]  entry;
        logic [WORD_W-1:0]  root;
        logic [WORD_W-1:0]  tick;
        logic [WORD_W-1:0]  exit_val;
        logic [VEC_W-1:0]   vec;
        logic [WORD_W-1:0]  faddr;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    pid;
        t_run               run;
        logic [WORD_W-1:0]  ret_code;
        logic [WORD_W-1:0]  elapsed;
        logic [VEC_W-1:0]   vec;
        logic [WORD_W-1:0]  addr;
        logic [WORD_W-1:0]  entry;
        logic [WORD_W-1:0]  root;
    } t_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [ID_W-1:0]          i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_op;
    logic [SLOT_W-1:0]        i_slot;
    logic [WORD_W-1:0]        i_entry_address;
    logic [WORD_W-1:0]        i_table_root;
    logic [WORD_W-1:0]        i_now_tick;
    logic signed [WORD_W-1:0] i_exit_value;
    logic [VEC_W-1:0]         i_fault_number;
    logic [WORD_W-1:0]        i_fault_address;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_status;
    logic [SLOT_W-1:0]        o_slot_out;
    logic [ID_W-1:0]          o_process_id;
    logic [1:0]               o_run_state;
    logic signed [WORD_W-1:0] o_exit_out;
    logic [WORD_W-1:0]        o_elapsed;
    logic [VEC_W-1:0]         o_vector_out;
    logic [WORD_W-1:0]        o_address_out;
    logic [WORD_W-1:0]        o_entry_out;
    logic [WORD_W-1:0]        o_root_out;

    // Slot table as the predictor sees it
    bit                tbl_used  [NUM_SLOTS];
    logic [ID_W-1:0]   tbl_id    [NUM_SLOTS];
    t_run              tbl_run   [NUM_SLOTS];
    logic [WORD_W-1:0] tbl_exit  [NUM_SLOTS];
    logic [WORD_W-1:0] tbl_entry [NUM_SLOTS];
    logic [WORD_W-1:0] tbl_root  [NUM_SLOTS];
    logic [WORD_W-1:0] tbl_start [NUM_SLOTS];
    logic [WORD_W-1:0] tbl_end   [NUM_SLOTS];
    logic [VEC_W-1:0]  tbl_vec   [NUM_SLOTS];
    logic [WORD_W-1:0] tbl_faddr [NUM_SLOTS];
    logic [ID_W-1:0]   next_pid;

    t_result           pending_results [$];
    t_request          req_offered;
    bit                req_pending;
    bit                idle_on;
    int                hold_cycles;
    int                mismatch_count;
    logic [WORD_W-1:0] tick_now;

    process_slot_table_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_slot          (i_slot),
        .i_entry_address (i_entry_address),
        .i_table_root    (i_table_root),
        .i_now_tick      (i_now_tick),
        .i_exit_value    (i_exit_value),
        .i_fault_number  (i_fault_number),
        .i_fault_address (i_fault_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot_out      (o_slot_out),
        .o_process_id    (o_process_id),
        .o_run_state     (o_run_state),
        .o_exit_out      (o_exit_out),
        .o_elapsed       (o_elapsed),
        .o_vector_out    (o_vector_out),
        .o_address_out   (o_address_out),
        .o_entry_out     (o_entry_out),
        .o_root_out      (o_root_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic t_result predict_slot_result(input t_request r);
        t_result         res;
        int              pick;
        int              i;
        bit              found;
        logic [ID_W-1:0] best;
        res   = '0;
        pick  = r.slot;
        found = 1'b0;
        best  = '0;
        if (r.op == OP_ALLOC) begin
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (!found && !tbl_used[i]) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            // no free slot: evict the finished process with the smallest id
            if (!found) begin
                for (i = 0; i < NUM_SLOTS; i++) begin
                    if (tbl_run[i] != RUN_RUNNING && (!found || tbl_id[i] < best)) begin
                        best  = tbl_id[i];
                        pick  = i;
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                res.status = ST_FULL;
                return res;
            end
            tbl_used[pick]  = 1'b1;
            tbl_id[pick]    = next_pid;
            next_pid        = next_pid + 1'b1;
            tbl_run[pick]   = RUN_RUNNING;
            tbl_exit[pick]  = '1;
            tbl_entry[pick] = r.entry;
            tbl_root[pick]  = r.root;
            tbl_start[pick] = r.tick;
            tbl_end[pick]   = '0;
            tbl_vec[pick]   = '0;
            tbl_faddr[pick] = '0;
        end else begin
            if (!tbl_used[pick]) begin
                res.status = ST_UNUSED;
                res.slot   = r.slot;
                return res;
            end
            case (r.op)
                OP_EXIT: begin
                    tbl_run[pick]  = RUN_EXITED;
                    tbl_exit[pick] = r.exit_val;
                    tbl_end[pick]  = r.tick;
                end
                OP_FAULT: begin
                    tbl_run[pick]   = RUN_FAULTED;
                    tbl_exit[pick]  = '1;
                    tbl_end[pick]   = r.tick;
                    tbl_vec[pick]   = r.vec;
                    tbl_faddr[pick] = r.faddr;
                end
                default: ;
            endcase
        end
        res.status    = ST_OK;
        res.slot      = pick[SLOT_W-1:0];
        res.pid       = tbl_id[pick];
        res.run       = tbl_run[pick];
        res.ret_code  = tbl_exit[pick];
        res.elapsed   = (tbl_end[pick] > tbl_start[pick]) ? tbl_end[pick] - tbl_start[pick]
                                                          : r.tick - tbl_start[pick];
        res.vec       = tbl_vec[pick];
        res.addr      = tbl_faddr[pick];
        res.entry     = tbl_entry[pick];
        res.root      = tbl_root[pick];
        return res;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf({"st=%0d slot=%0d pid=%h run=%0d exit=%h elapsed=%h",
                          " vec=%h addr=%h entry=%h root=%h"},
                         r.status, r.slot, r.pid, r.run, r.ret_code, r.elapsed,
                         r.vec, r.addr, r.entry, r.root);
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly a rising clock, now and then an arbitrary value
    function automatic logic [WORD_W-1:0] next_tick();
        if ($urandom_range(0, 99) < 80) begin
            tick_now = tick_now + $urandom_range(0, 5000);
            return tick_now;
        end
        return rand64();
    endfunction

    function automatic t_request make_req(input t_op op, input logic [SLOT_W-1:0] slot);
        t_request r;
        r.op    = op;
        r.slot  = slot;
        r.entry = rand64();
        r.root  = rand64();
        r.tick  = next_tick();
        case ($urandom_range(0, 9))
            0:       r.exit_val = '0;
            1:       r.exit_val = '1;
            2:       r.exit_val = {1'b1, {(WORD_W-1){1'b0}}};
            3:       r.exit_val = {1'b0, {(WORD_W-1){1'b1}}};
            default: r.exit_val = rand64();
        endcase
        r.vec   = VEC_W'($urandom);
        r.faddr = rand64();
        return r;
    endfunction

    // Mostly a slot in use, so exit, fault and query do real work
    function automatic logic [SLOT_W-1:0] pick_slot();
        int used [$];
        int i;
        for (i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_used[i]) used.push_back(i);
        end
        if (used.size() == 0 || $urandom_range(0, 99) < 15) return SLOT_W'($urandom);
        return SLOT_W'(used[$urandom_range(0, used.size() - 1)]);
    endfunction

    function automatic t_op random_op(input int alloc_pct, input int exit_pct,
                                      input int fault_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) return OP_ALLOC;
        if (roll < alloc_pct + exit_pct) return OP_EXIT;
        if (roll < alloc_pct + exit_pct + fault_pct) return OP_FAULT;
        return OP_QUERY;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    task automatic wait_accept();
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_slot_result(req_offered));
        req_pending = 1'b0;
    endtask

    // Offer one request; it stays on the port until the next call or a drain
    task automatic send_request(input t_request r);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
        if (req_pending) begin
            wait_accept();
            if (gap > 0) i_in_valid <= 1'b0;
        end
        repeat (gap) @(posedge i_clk);
        i_in_valid      <= 1'b1;
        i_op            <= r.op;
        i_slot          <= r.slot;
        i_entry_address <= r.entry;
        i_table_root    <= r.root;
        i_now_tick      <= r.tick;
        i_exit_value    <= r.exit_val;
        i_fault_number  <= r.vec;
        i_fault_address <= r.faddr;
        req_offered = r;
        req_pending = 1'b1;
    endtask

    task automatic drain_results();
        if (req_pending) begin
            wait_accept();
            i_in_valid <= 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_first_id(input logic [ID_W-1:0] value);
        drain_results();
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        next_pid = value;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    initial begin : stall_gen
        int burst;
        burst = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles == 0 && burst == 0 && idle_on && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 19);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : result_check
        t_result got;
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = '{status: t_status'(o_status), slot: o_slot_out, pid: o_process_id,
                        run: t_run'(o_run_state), ret_code: o_exit_out,
                        elapsed: o_elapsed, vec: o_vector_out, addr: o_address_out,
                        entry: o_entry_out, root: o_root_out};
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no request waiting: %s",
                                 $realtime, fmt_result(got));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: mismatch, expected %s", $realtime, fmt_result(want));
                            $display("%0t:           actual   %s", $realtime, fmt_result(got));
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Starts from reset: slots 0, 1 and 2 get allocated here
    task automatic test_directed_ops();
        t_request r;
        r = make_req(OP_QUERY, 5'd0);
        send_request(r);
        r = make_req(OP_EXIT, 5'd31);
        send_request(r);
        r = make_req(OP_FAULT, 5'd17);
        send_request(r);
        r = make_req(OP_ALLOC, 5'd0);
        r.entry = '1;
        r.root  = '0;
        r.tick  = '1;
        send_request(r);
        r = make_req(OP_ALLOC, 5'd31);
        r.entry = '0;
        r.root  = '1;
        r.tick  = '0;
        send_request(r);
        // elapsed wraps past the top of the tick range
        r = make_req(OP_QUERY, 5'd0);
        r.tick = 64'd5;
        send_request(r);
        r = make_req(OP_QUERY, 5'd1);
        r.tick = '0;
        send_request(r);
        // end tick below start tick: elapsed falls back to now minus start
        r = make_req(OP_EXIT, 5'd0);
        r.exit_val = {1'b1, {(WORD_W-1){1'b0}}};
        r.tick     = 64'd10;
        send_request(r);
        r = make_req(OP_EXIT, 5'd1);
        r.exit_val = {1'b0, {(WORD_W-1){1'b1}}};
        r.tick     = 64'd1000;
        send_request(r);
        // finish already finished slots again
        r = make_req(OP_FAULT, 5'd1);
        r.vec   = '1;
        r.faddr = '1;
        r.tick  = 64'd2000;
        send_request(r);
        r = make_req(OP_FAULT, 5'd0);
        r.vec   = '0;
        r.faddr = '0;
        r.tick  = '1;
        send_request(r);
        r = make_req(OP_EXIT, 5'd1);
        r.exit_val = '1;
        r.tick     = 64'd3000;
        send_request(r);
        send_request(make_req(OP_QUERY, 5'd1));
        send_request(make_req(OP_QUERY, 5'd2));
        r = make_req(OP_ALLOC, 5'd0);
        r.tick = 64'd5;
        send_request(r);
        r = make_req(OP_FAULT, 5'd2);
        r.vec  = 8'h5A;
        r.tick = 64'd6;
        send_request(r);
        send_request(make_req(OP_QUERY, 5'd31));
        drain_results();
    endtask

    // Id counter load, wrap and duplicate ids
    task automatic test_first_id();
        write_first_id('1);
        send_request(make_req(OP_ALLOC, 5'd0));
        send_request(make_req(OP_ALLOC, 5'd0));
        write_first_id('0);
        send_request(make_req(OP_ALLOC, 5'd0));
        write_first_id($urandom);
        send_request(make_req(OP_ALLOC, 5'd0));
        drain_results();
    endtask

    task automatic test_fill_and_evict();
        int n;
        write_first_id(32'hFFFF_0000);
        // fill free slots, evict the finished ones, then hit a full table
        for (n = 0; n < 34; n++) send_request(make_req(OP_ALLOC, pick_slot()));
        // two finished slots with the same id: the lower index is evicted first
        write_first_id(32'd100);
        send_request(make_req(OP_EXIT, 5'd9));
        send_request(make_req(OP_ALLOC, 5'd0));
        write_first_id(32'd100);
        send_request(make_req(OP_EXIT, 5'd4));
        send_request(make_req(OP_ALLOC, 5'd0));
        send_request(make_req(OP_EXIT, 5'd20));
        send_request(make_req(OP_EXIT, 5'd9));
        send_request(make_req(OP_FAULT, 5'd4));
        for (n = 0; n < 4; n++) send_request(make_req(OP_ALLOC, 5'd0));
        drain_results();
    endtask

    // Hold the result side long enough for the block to stall its input
    task automatic test_long_hold();
        int n;
        idle_on = 1'b0;
        hold_cycles = 300;
        for (n = 0; n < 12; n++)
            send_request(make_req(random_op(30, 30, 20), pick_slot()));
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic run_random_phase(input int count, input logic [ID_W-1:0] first,
                                    input int alloc_pct, input int exit_pct,
                                    input int fault_pct, input bit idling);
        int n;
        write_first_id(first);
        idle_on = idling;
        for (n = 0; n < count; n++)
            send_request(make_req(random_op(alloc_pct, exit_pct, fault_pct), pick_slot()));
        drain_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(250, '0, 40, 25, 15, 1'b1);
        // allocation heavy: the table runs full and the ids wrap
        run_random_phase(250, 32'hFFFF_FFF0, 65, 10, 5, 1'b1);
        run_random_phase(300, $urandom, 30, 30, 20, 1'b1);
        run_random_phase(300, FIRST_ID_RESET, 35, 25, 15, 1'b0);
    endtask

    initial begin
        int i;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_in_valid      = 1'b0;
        i_op            = OP_ALLOC;
        i_slot          = '0;
        i_entry_address = '0;
        i_table_root    = '0;
        i_now_tick      = '0;
        i_exit_value    = '0;
        i_fault_number  = '0;
        i_fault_address = '0;
        idle_on         = 1'b1;
        hold_cycles     = 0;
        mismatch_count  = 0;
        req_pending     = 1'b0;
        tick_now        = '0;
        next_pid        = FIRST_ID_RESET;
        for (i = 0; i < NUM_SLOTS; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_id[i]    = '0;
            tbl_run[i]   = RUN_EMPTY;
            tbl_exit[i]  = '0;
            tbl_entry[i] = '0;
            tbl_root[i]  = '0;
            tbl_start[i] = '0;
            tbl_end[i]   = '0;
            tbl_vec[i]   = '0;
            tbl_faddr[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_first_id();
        test_fill_and_evict();
        test_long_hold();
        test_random_traffic();

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
